// File: src/gcim_pkg.sv
// ----------------------------------------------------------------------------
// gcim_pkg
// Shared types, constants and helpers for the grid coordinate index mapper.
// ----------------------------------------------------------------------------
package gcim_pkg;

  localparam int MAX_DIM    = 1024;
  localparam int COORD_BITS = 16;
  localparam int IDX_BITS   = 38;
  localparam int IDXIN_BITS = 30;
  localparam int SIZE_BITS  = 11;
  localparam int REM_BITS   = 10;
  localparam int SXY_BITS   = 2 * SIZE_BITS - 1;
  localparam int SXYZ_BITS  = 3 * SIZE_BITS - 2;

  // opcodes
  localparam logic [1:0] OP_TO_INDEX = 2'd0;
  localparam logic [1:0] OP_TO_COORD = 2'd1;
  localparam logic [1:0] OP_OFFSET   = 2'd2;

  // register indexes
  localparam logic [2:0] REG_ORIGIN_X = 3'd0;
  localparam logic [2:0] REG_ORIGIN_Y = 3'd1;
  localparam logic [2:0] REG_ORIGIN_Z = 3'd2;
  localparam logic [2:0] REG_SIZE_X   = 3'd3;
  localparam logic [2:0] REG_SIZE_Y   = 3'd4;
  localparam logic [2:0] REG_SIZE_Z   = 3'd5;

  typedef struct packed {
    logic [1:0]                  opcode;
    logic signed [COORD_BITS-1:0] coord_x;
    logic signed [COORD_BITS-1:0] coord_y;
    logic signed [COORD_BITS-1:0] coord_z;
    logic [IDXIN_BITS-1:0]       index_in;
  } in_req_t;

  typedef struct packed {
    logic signed [IDX_BITS-1:0]   index_out;
    logic signed [COORD_BITS-1:0] out_x;
    logic signed [COORD_BITS-1:0] out_y;
    logic signed [COORD_BITS-1:0] out_z;
    logic                         interior;
    logic                         out_of_box;
  } out_res_t;

  // request state handed from cell to cell
  typedef struct packed {
    logic                       valid;
    logic [1:0]                 op;
    logic [IDXIN_BITS-1:0]      num;
    logic [REM_BITS-1:0]        rem;
    logic [REM_BITS-1:0]        rem_x;
    logic signed [IDX_BITS-1:0] idx_out;
    logic                       interior;
    logic                       oob;
  } lane_t;

  // zero acts as one, anything above the limit acts as the limit
  function automatic logic [SIZE_BITS-1:0] eff_size(input logic [SIZE_BITS-1:0] s);
    logic [SIZE_BITS-1:0] r;
    if (s == '0) begin
      r = SIZE_BITS'(1);
    end else if (s > SIZE_BITS'(MAX_DIM)) begin
      r = SIZE_BITS'(MAX_DIM);
    end else begin
      r = s;
    end
    return r;
  endfunction

  // clamp to the coordinate range
  function automatic logic signed [COORD_BITS-1:0] sat_coord(input logic signed [31:0] v);
    logic signed [COORD_BITS-1:0] r;
    if (v > 32'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -32'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[COORD_BITS-1:0];
    end
    return r;
  endfunction

endpackage

// File: src/gcim_div_cell.sv
// ----------------------------------------------------------------------------
// gcim_div_cell
// One restoring division step: shifts in a dividend bit, emits a quotient bit.
// ----------------------------------------------------------------------------
module gcim_div_cell (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           en,
  input  logic [gcim_pkg::SIZE_BITS-1:0] divisor,
  input  gcim_pkg::lane_t                lane_i,
  output gcim_pkg::lane_t                lane_o
);

  gcim_pkg::lane_t                lane_r;
  gcim_pkg::lane_t                lane_nxt;
  logic [gcim_pkg::SIZE_BITS-1:0] trial;
  logic [gcim_pkg::SIZE_BITS:0]   diff;
  logic                           qbit;

  // trial subtract of the divisor from the partial remainder
  always_comb begin
    trial    = {lane_i.rem, lane_i.num[gcim_pkg::IDXIN_BITS-1]};
    diff     = {1'b0, trial} - {1'b0, divisor};
    qbit     = ~diff[gcim_pkg::SIZE_BITS];
    lane_nxt = lane_i;
    lane_nxt.rem = qbit ? diff[gcim_pkg::REM_BITS-1:0] : trial[gcim_pkg::REM_BITS-1:0];
    lane_nxt.num = {lane_i.num[gcim_pkg::IDXIN_BITS-2:0], qbit};
  end

  // stage register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lane_r.valid <= 1'b0;
    end else if (en) begin
      lane_r <= lane_nxt;
    end
  end

  assign lane_o = lane_r;

endmodule

// File: src/gcim_front.sv
// ----------------------------------------------------------------------------
// gcim_front
// Three-stage front end: displacement, products and bounds, index sum.
// ----------------------------------------------------------------------------
module gcim_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            en,
  input  logic                            in_valid,
  input  gcim_pkg::in_req_t               in_req,
  input  logic signed [15:0]              org_x,
  input  logic signed [15:0]              org_y,
  input  logic signed [15:0]              org_z,
  input  logic [gcim_pkg::SIZE_BITS-1:0]  sx,
  input  logic [gcim_pkg::SIZE_BITS-1:0]  sy,
  input  logic [gcim_pkg::SIZE_BITS-1:0]  sz,
  input  logic [gcim_pkg::SXY_BITS-1:0]   sxy,
  input  logic [gcim_pkg::SXYZ_BITS-1:0]  sxyz,
  output gcim_pkg::lane_t                 lane_o
);

  // stage a
  logic                              a_valid_r;
  logic [1:0]                        a_op_r;
  logic [gcim_pkg::IDXIN_BITS-1:0]   a_idx_r;
  logic signed [16:0]                a_dx_r, a_dy_r, a_dz_r;
  logic signed [16:0]                dx_nxt, dy_nxt, dz_nxt;
  // stage b
  logic                              b_valid_r;
  logic [1:0]                        b_op_r;
  logic [gcim_pkg::IDXIN_BITS-1:0]   b_idx_r;
  logic signed [16:0]                b_dx_r;
  logic signed [28:0]                b_py_r;
  logic signed [38:0]                b_pz_r;
  logic                              b_oob_r, b_int_r;
  logic                              oob_nxt, int_nxt;
  logic signed [17:0]                dxe, dye, dze, sxs, sys, szs;
  // stage c
  gcim_pkg::lane_t                   lane_r;
  gcim_pkg::lane_t                   lane_nxt;
  logic signed [38:0]                sum;

  // displacement from the box corner, or the raw displacement
  always_comb begin
    if (in_req.opcode == gcim_pkg::OP_TO_INDEX) begin
      dx_nxt = 17'(in_req.coord_x) - 17'(org_x);
      dy_nxt = 17'(in_req.coord_y) - 17'(org_y);
      dz_nxt = 17'(in_req.coord_z) - 17'(org_z);
    end else begin
      dx_nxt = 17'(in_req.coord_x);
      dy_nxt = 17'(in_req.coord_y);
      dz_nxt = 17'(in_req.coord_z);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (en) begin
      a_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_op_r  <= in_req.opcode;
      a_idx_r <= in_req.index_in;
      a_dx_r  <= dx_nxt;
      a_dy_r  <= dy_nxt;
      a_dz_r  <= dz_nxt;
    end
  end

  // box and interior bounds on every axis
  always_comb begin
    dxe = 18'(a_dx_r);
    dye = 18'(a_dy_r);
    dze = 18'(a_dz_r);
    sxs = $signed({7'd0, sx});
    sys = $signed({7'd0, sy});
    szs = $signed({7'd0, sz});
    oob_nxt = (dxe < 18'sd0) || (dxe >= sxs) || (dye < 18'sd0) || (dye >= sys) ||
              (dze < 18'sd0) || (dze >= szs);
    int_nxt = (dxe >= 18'sd1) && (dxe <= sxs - 18'sd2) &&
              (dye >= 18'sd1) && (dye <= sys - 18'sd2) &&
              (dze >= 18'sd1) && (dze <= szs - 18'sd2);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (en) begin
      b_valid_r <= a_valid_r;
    end
  end

  // row and plane products
  always_ff @(posedge clk) begin
    if (en) begin
      b_op_r  <= a_op_r;
      b_idx_r <= a_idx_r;
      b_dx_r  <= a_dx_r;
      b_py_r  <= a_dy_r * $signed({1'b0, sx});
      b_pz_r  <= a_dz_r * $signed({1'b0, sxy});
      b_oob_r <= oob_nxt;
      b_int_r <= int_nxt;
    end
  end

  // index sum and per-opcode flags
  always_comb begin
    sum = 39'(b_dx_r) + 39'(b_py_r) + b_pz_r;
    lane_nxt          = '0;
    lane_nxt.valid    = b_valid_r;
    lane_nxt.op       = b_op_r;
    lane_nxt.num      = b_idx_r;
    case (b_op_r)
      gcim_pkg::OP_TO_INDEX: begin
        lane_nxt.idx_out  = sum[gcim_pkg::IDX_BITS-1:0];
        lane_nxt.oob      = b_oob_r;
        lane_nxt.interior = b_int_r;
      end
      gcim_pkg::OP_OFFSET: begin
        lane_nxt.idx_out  = sum[gcim_pkg::IDX_BITS-1:0];
      end
      gcim_pkg::OP_TO_COORD: begin
        lane_nxt.oob      = {1'b0, b_idx_r} >= sxyz;
      end
      default: begin
        lane_nxt.idx_out  = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lane_r.valid <= 1'b0;
    end else if (en) begin
      lane_r <= lane_nxt;
    end
  end

  assign lane_o = lane_r;

endmodule

// File: src/grid_coord_index_mapper.sv
// ----------------------------------------------------------------------------
// grid_coord_index_mapper
// Row-major 3D coordinate/index mapper with a pipelined divider chain.
//
//   channel  ports                               direction
//   in       in_valid, in_ready, in_req          request in
//   out      out_valid, out_ready, out_res       result out
//   cfg      cfg_psel/penable/pwrite/paddr/...   register access
//
// One request per cycle unless stalled; the chain holds three front stages, 60 divider
// cells (30 for the x divide, 30 for the y divide) and the output register.
// The whole chain advances together; it stalls only while a result waits
// in the output register and out_ready is low.
// Synchronous active-low reset clears valid bits and the origin registers and sets the sizes to one.
// ----------------------------------------------------------------------------
module grid_coord_index_mapper (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  gcim_pkg::in_req_t   in_req,
  output logic                out_valid,
  input  logic                out_ready,
  output gcim_pkg::out_res_t  out_res,
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [4:0]          cfg_paddr,
  input  logic [31:0]         cfg_pwdata,
  output logic [31:0]         cfg_prdata,
  output logic                cfg_pready
);

  localparam int NCELLS = 2 * gcim_pkg::IDXIN_BITS;

  logic signed [15:0]                org_x_r, org_y_r, org_z_r;
  logic [gcim_pkg::SIZE_BITS-1:0]    size_x_r, size_y_r, size_z_r;
  logic [gcim_pkg::SIZE_BITS-1:0]    sx, sy, sz;
  logic [gcim_pkg::SXY_BITS-1:0]     sxy_r;
  logic [gcim_pkg::SXYZ_BITS-1:0]    sxyz_r;
  logic [2:0]                        reg_idx;
  logic                              wr_en;
  logic                              en;
  gcim_pkg::lane_t                   lane_w [0:NCELLS];
  gcim_pkg::lane_t                   handoff;
  gcim_pkg::lane_t                   last;
  logic                              out_valid_r;
  gcim_pkg::out_res_t                out_res_r;
  gcim_pkg::out_res_t                res_nxt;

  // register port
  assign reg_idx    = cfg_paddr[4:2];
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      org_x_r  <= '0;
      org_y_r  <= '0;
      org_z_r  <= '0;
      size_x_r <= gcim_pkg::SIZE_BITS'(1);
      size_y_r <= gcim_pkg::SIZE_BITS'(1);
      size_z_r <= gcim_pkg::SIZE_BITS'(1);
    end else if (wr_en) begin
      case (reg_idx)
        gcim_pkg::REG_ORIGIN_X: org_x_r  <= cfg_pwdata[15:0];
        gcim_pkg::REG_ORIGIN_Y: org_y_r  <= cfg_pwdata[15:0];
        gcim_pkg::REG_ORIGIN_Z: org_z_r  <= cfg_pwdata[15:0];
        gcim_pkg::REG_SIZE_X:   size_x_r <= cfg_pwdata[gcim_pkg::SIZE_BITS-1:0];
        gcim_pkg::REG_SIZE_Y:   size_y_r <= cfg_pwdata[gcim_pkg::SIZE_BITS-1:0];
        gcim_pkg::REG_SIZE_Z:   size_z_r <= cfg_pwdata[gcim_pkg::SIZE_BITS-1:0];
        default: ;
      endcase
    end
  end

  // readback
  always_comb begin
    case (reg_idx)
      gcim_pkg::REG_ORIGIN_X: cfg_prdata = {16'd0, org_x_r};
      gcim_pkg::REG_ORIGIN_Y: cfg_prdata = {16'd0, org_y_r};
      gcim_pkg::REG_ORIGIN_Z: cfg_prdata = {16'd0, org_z_r};
      gcim_pkg::REG_SIZE_X:   cfg_prdata = 32'(size_x_r);
      gcim_pkg::REG_SIZE_Y:   cfg_prdata = 32'(size_y_r);
      gcim_pkg::REG_SIZE_Z:   cfg_prdata = 32'(size_z_r);
      default:                cfg_prdata = '0;
    endcase
  end

  // effective sizes and their registered products
  assign sx = gcim_pkg::eff_size(size_x_r);
  assign sy = gcim_pkg::eff_size(size_y_r);
  assign sz = gcim_pkg::eff_size(size_z_r);

  always_ff @(posedge clk) begin
    sxy_r  <= {10'd0, sx} * {10'd0, sy};
    sxyz_r <= {10'd0, sxy_r} * {20'd0, sz};
  end

  // chain advances unless a result is held
  assign en       = ~out_valid_r | out_ready;
  assign in_ready = en;

  gcim_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_valid),
    .in_req   (in_req),
    .org_x    (org_x_r),
    .org_y    (org_y_r),
    .org_z    (org_z_r),
    .sx       (sx),
    .sy       (sy),
    .sz       (sz),
    .sxy      (sxy_r),
    .sxyz     (sxyz_r),
    .lane_o   (lane_w[0])
  );

  // keep the x remainder, restart the remainder for the y divide
  always_comb begin
    handoff       = lane_w[gcim_pkg::IDXIN_BITS];
    handoff.rem_x = lane_w[gcim_pkg::IDXIN_BITS].rem;
    handoff.rem   = '0;
  end

  // divider chain: first half by size_x, second half by size_y
  for (genvar i = 0; i < NCELLS; i++) begin : g_cell
    if (i == gcim_pkg::IDXIN_BITS) begin : g_hand
      gcim_div_cell u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .divisor (sy),
        .lane_i  (handoff),
        .lane_o  (lane_w[i+1])
      );
    end else begin : g_plain
      gcim_div_cell u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .divisor ((i < gcim_pkg::IDXIN_BITS) ? sx : sy),
        .lane_i  (lane_w[i]),
        .lane_o  (lane_w[i+1])
      );
    end
  end

  // final coordinates with saturation
  assign last = lane_w[NCELLS];

  always_comb begin
    res_nxt            = '0;
    res_nxt.index_out  = last.idx_out;
    res_nxt.interior   = last.interior;
    res_nxt.out_of_box = last.oob;
    if (last.op == gcim_pkg::OP_TO_COORD) begin
      res_nxt.out_x = gcim_pkg::sat_coord(32'(org_x_r) + $signed({22'd0, last.rem_x}));
      res_nxt.out_y = gcim_pkg::sat_coord(32'(org_y_r) + $signed({22'd0, last.rem}));
      res_nxt.out_z = gcim_pkg::sat_coord(32'(org_z_r) + $signed({2'd0, last.num}));
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= last.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_res_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

// File: bench/grid_coord_index_mapper_tb.sv
// ----------------------------------------------------------------------------
// grid_coord_index_mapper_tb
// Self-checking bench for the grid coordinate index mapper: random requests
// of every opcode across several box settings, each result checked against
// a behavioral prediction of the linearization, its inverse and offsets.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module grid_coord_index_mapper_tb;

  localparam int LATENCY   = 64;
  localparam int MAX_CYCLE = 400000;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  gcim_pkg::in_req_t in_req;
  logic out_valid;
  logic out_ready;
  gcim_pkg::out_res_t out_res;
  logic cfg_psel;
  logic cfg_penable;
  logic cfg_pwrite;
  logic [4:0] cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  grid_coord_index_mapper dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_req(in_req),
    .out_valid(out_valid), .out_ready(out_ready), .out_res(out_res),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  // box registers as the bench believes them
  logic signed [15:0] box_org [3];
  logic [10:0]        box_size [3];

  gcim_pkg::in_req_t  pending_reqs [$];
  gcim_pkg::out_res_t expected_res [$];
  int  mismatches;
  int  cycle;
  bit  hold_input;
  bit  in_taken;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic longint clamp_size(input logic [10:0] s);
    longint r;
    if (s == 0) r = 1;
    else if (s > gcim_pkg::MAX_DIM) r = gcim_pkg::MAX_DIM;
    else r = s;
    return r;
  endfunction

  function automatic logic signed [15:0] clamp_coord(input longint v);
    logic signed [15:0] r;
    if (v > 32767) r = 16'sh7fff;
    else if (v < -32768) r = 16'sh8000;
    else r = v[15:0];
    return r;
  endfunction

  function automatic logic signed [37:0] clamp_index(input longint v);
    logic signed [37:0] r;
    longint hi;
    longint lo;
    hi = (longint'(1) <<< 37) - 1;
    lo = -hi - 1;
    if (v > hi) r = hi[37:0];
    else if (v < lo) r = lo[37:0];
    else r = v[37:0];
    return r;
  endfunction

  // predicted mapping for one request
  function automatic gcim_pkg::out_res_t map_request(input gcim_pkg::in_req_t q);
    gcim_pkg::out_res_t r;
    longint d [3];
    longint o [3];
    longint s [3];
    longint idx, t;
    bit oob, inter;
    r = '0;
    for (int a = 0; a < 3; a++) begin
      o[a] = box_org[a];
      s[a] = clamp_size(box_size[a]);
    end
    d[0] = q.coord_x;
    d[1] = q.coord_y;
    d[2] = q.coord_z;
    if (q.opcode == gcim_pkg::OP_TO_INDEX || q.opcode == gcim_pkg::OP_OFFSET) begin
      if (q.opcode == gcim_pkg::OP_TO_INDEX) begin
        oob = 0;
        inter = 1;
        for (int a = 0; a < 3; a++) begin
          d[a] = d[a] - o[a];
          if (d[a] < 0 || d[a] >= s[a]) oob = 1;
          if (!(d[a] >= 1 && d[a] <= s[a] - 2)) inter = 0;
        end
        r.out_of_box = oob;
        r.interior = inter;
      end
      r.index_out = clamp_index(d[0] + d[1] * s[0] + d[2] * s[0] * s[1]);
    end else if (q.opcode == gcim_pkg::OP_TO_COORD) begin
      idx = q.index_in;
      t = idx / s[0];
      r.out_of_box = (idx >= s[0] * s[1] * s[2]);
      r.out_x = clamp_coord(o[0] + idx % s[0]);
      r.out_y = clamp_coord(o[1] + t % s[1]);
      r.out_z = clamp_coord(o[2] + t / s[1]);
    end
    return r;
  endfunction

  // append a request to the pending queue
  function automatic void add_req(input gcim_pkg::in_req_t q);
    pending_reqs.insert(pending_reqs.size(), q);
  endfunction

  // register write through the apb port, setup then access
  task automatic write_reg(input logic [2:0] which, input logic [31:0] value);
    @(negedge clk);
    cfg_psel = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b1;
    cfg_paddr = {which, 2'b00};
    cfg_pwdata = value;
    @(negedge clk);
    cfg_penable = 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    @(negedge clk);
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    if (which <= gcim_pkg::REG_ORIGIN_Z) box_org[which] = value[15:0];
    else box_size[which - gcim_pkg::REG_SIZE_X] = value[10:0];
  endtask

  task automatic set_box(input logic [15:0] ox, input logic [15:0] oy, input logic [15:0] oz,
                         input logic [10:0] sx, input logic [10:0] sy, input logic [10:0] sz);
    write_reg(gcim_pkg::REG_ORIGIN_X, {16'h0, ox});
    write_reg(gcim_pkg::REG_ORIGIN_Y, {16'h0, oy});
    write_reg(gcim_pkg::REG_ORIGIN_Z, {16'h0, oz});
    write_reg(gcim_pkg::REG_SIZE_X, {21'h0, sx});
    write_reg(gcim_pkg::REG_SIZE_Y, {21'h0, sy});
    write_reg(gcim_pkg::REG_SIZE_Z, {21'h0, sz});
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || in_valid || expected_res.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  function automatic gcim_pkg::in_req_t make_req(input logic [1:0] op, input logic [15:0] x,
                                                 input logic [15:0] y, input logic [15:0] z,
                                                 input logic [29:0] idx);
    gcim_pkg::in_req_t q;
    q.opcode = op;
    q.coord_x = x;
    q.coord_y = y;
    q.coord_z = z;
    q.index_in = idx;
    return q;
  endfunction

  // mostly points near the box, some anywhere
  function automatic logic [15:0] near_coord(input int a);
    logic [15:0] v;
    if ($urandom_range(0, 3) == 0) v = 16'($urandom);
    else v = box_org[a] +
             16'($signed($urandom_range(0, 32'(clamp_size(box_size[a]) + 3))) - 2);
    return v;
  endfunction

  function automatic gcim_pkg::in_req_t rand_req();
    logic [1:0] op;
    longint tot;
    logic [29:0] idx;
    op = $urandom_range(0, 15) == 0 ? OP_UNUSED : 2'($urandom_range(0, 2));
    tot = clamp_size(box_size[0]) * clamp_size(box_size[1]) * clamp_size(box_size[2]);
    if ($urandom_range(0, 3) == 0) idx = 30'($urandom);
    else idx = 30'($urandom_range(0, 32'(tot + 2)));
    if (op == gcim_pkg::OP_OFFSET)
      return make_req(op, 16'($urandom), 16'($urandom), 16'($urandom), idx);
    return make_req(op, near_coord(0), near_coord(1), near_coord(2), idx);
  endfunction

  // request accepted at the last rising edge
  always @(posedge clk) begin
    in_taken <= rst_n && in_valid && in_ready;
  end

  // input driver
  int in_gap;
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap <= $urandom_range(0, 16);
    end else if (in_valid && !in_taken) begin
      // request still waiting, hold it
    end else if (in_gap != 0) begin
      in_valid <= 1'b0;
      in_gap <= in_gap - 1;
    end else if (pending_reqs.size() != 0 && !hold_input) begin
      in_valid <= 1'b1;
      in_req <= pending_reqs[0];
      expected_res.insert(expected_res.size(), map_request(pending_reqs[0]));
      void'(pending_reqs.pop_front());
      in_gap <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16) : 0;
    end else begin
      in_valid <= 1'b0;
    end
  end

  // result side stalls and checking
  int out_gap;
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      out_gap <= 0;
    end else if (out_gap != 0) begin
      out_ready <= 1'b0;
      out_gap <= out_gap - 1;
    end else begin
      out_ready <= 1'b1;
      if ($urandom_range(0, 7) == 0) out_gap <= $urandom_range(0, 16);
    end
  end

  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (rst_n && out_valid && out_ready) begin
      if (expected_res.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", out_res);
      end else begin
        if (out_res !== expected_res[0]) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: exp idx %0d xyz %0d %0d %0d int %b oob %b",
                     expected_res[0].index_out, expected_res[0].out_x,
                     expected_res[0].out_y, expected_res[0].out_z,
                     expected_res[0].interior, expected_res[0].out_of_box);
            $display("          got idx %0d xyz %0d %0d %0d int %b oob %b",
                     out_res.index_out, out_res.out_x, out_res.out_y, out_res.out_z,
                     out_res.interior, out_res.out_of_box);
          end
        end
        void'(expected_res.pop_front());
      end
    end
    if (cycle >= MAX_CYCLE) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_req = '0;
    out_ready = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    mismatches = 0;
    cycle = 0;
    hold_input = 0;
    for (int a = 0; a < 3; a++) begin
      box_org[a] = 0;
      box_size[a] = 1;
    end
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: reset box, then extremes including zero and oversized sizes
    add_req(make_req(gcim_pkg::OP_TO_INDEX, 16'h0, 16'h0, 16'h0, 30'd0));
    add_req(make_req(gcim_pkg::OP_TO_COORD, 16'h0, 16'h0, 16'h0, 30'h3fffffff));
    add_req(make_req(OP_UNUSED, 16'hffff, 16'hffff, 16'hffff, 30'h3fffffff));
    wait_drained();
    set_box(16'h8000, 16'h7fff, 16'h0000, 11'd0, 11'd2047, 11'd1024);
    add_req(make_req(gcim_pkg::OP_TO_INDEX, 16'h8000, 16'h7fff, 16'h0000, 30'd0));
    add_req(make_req(gcim_pkg::OP_TO_INDEX, 16'h7fff, 16'h8000, 16'hffff, 30'd0));
    add_req(make_req(gcim_pkg::OP_TO_COORD, 16'h0, 16'h0, 16'h0, 30'h3fffffff));
    add_req(make_req(gcim_pkg::OP_TO_COORD, 16'h0, 16'h0, 16'h0, 30'd1048575));
    add_req(make_req(gcim_pkg::OP_OFFSET, 16'h7fff, 16'h7fff, 16'h7fff, 30'd0));
    add_req(make_req(gcim_pkg::OP_OFFSET, 16'h8000, 16'h8000, 16'h8000, 30'd0));
    wait_drained();
    set_box(16'h7ff0, 16'h8000, 16'hfffe, 11'd1024, 11'd1024, 11'd1024);
    add_req(make_req(gcim_pkg::OP_TO_INDEX, 16'h7fff, 16'h8001, 16'hffff, 30'd0));
    add_req(make_req(gcim_pkg::OP_TO_INDEX, 16'h8000, 16'h7fff, 16'h7fff, 30'd0));
    add_req(make_req(gcim_pkg::OP_TO_COORD, 16'h0, 16'h0, 16'h0, 30'h3fffffff));
    add_req(make_req(gcim_pkg::OP_TO_COORD, 16'h0, 16'h0, 16'h0, 30'd1023));
    add_req(make_req(gcim_pkg::OP_OFFSET, 16'h7fff, 16'h7fff, 16'h7fff, 30'd0));
    add_req(make_req(gcim_pkg::OP_OFFSET, 16'h8000, 16'h8000, 16'h8000, 30'd0));
    wait_drained();
    set_box(16'd5, 16'hfffb, 16'd3, 11'd3, 11'd4, 11'd5);
    add_req(make_req(gcim_pkg::OP_TO_INDEX, 16'd6, 16'hfffc, 16'd4, 30'd0));
    add_req(make_req(gcim_pkg::OP_TO_INDEX, 16'd7, 16'hfffe, 16'd7, 30'd0));
    add_req(make_req(gcim_pkg::OP_TO_INDEX, 16'd8, 16'hfffe, 16'd7, 30'd0));
    add_req(make_req(gcim_pkg::OP_TO_COORD, 16'h0, 16'h0, 16'h0, 30'd59));
    add_req(make_req(gcim_pkg::OP_TO_COORD, 16'h0, 16'h0, 16'h0, 30'd60));

    // random phases over assorted boxes
    for (int ph = 0; ph < 8; ph++) begin
      wait_drained();
      if (ph == 3) begin
        set_box(16'($urandom), 16'($urandom), 16'($urandom),
                11'($urandom), 11'($urandom), 11'($urandom));
      end else begin
        set_box(16'($urandom), 16'($urandom), 16'($urandom),
                ph[0] ? 11'($urandom_range(1, 12)) : 11'($urandom_range(0, 1100)),
                11'($urandom_range(0, 40)), 11'($urandom_range(0, 1100)));
      end
      for (int n = 0; n < 240; n++) add_req(rand_req());
      if (ph == 5) begin
        // hold the sender until everything issued so far has come back
        while (pending_reqs.size() > 120 || in_valid) @(posedge clk);
        hold_input = 1;
        while (expected_res.size() != 0) @(posedge clk);
        @(negedge clk);
        hold_input = 0;
      end
    end
    wait_drained();

    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
